[rtl/core/bdsc_pkg.sv]
package bdsc_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned IVL_W       = 8;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  // compare width covers both sample and target
  localparam int unsigned CMP_W = (SAMPLE_BITS > POS_W) ? SAMPLE_BITS : POS_W;

  // targets keep only as many bits as a sample carries
  localparam logic [31:0] SAMPLE_MASK32 = (32'd1 << SAMPLE_BITS) - 32'd1;
  localparam logic [POS_W-1:0] POS_MASK = SAMPLE_MASK32[POS_W-1:0];

  localparam logic [KEY_W-1:0] KEY_LIMIT = 8'd127;

  // key bit positions, active low
  localparam int unsigned KEY_A_UP   = 0;
  localparam int unsigned KEY_A_DOWN = 1;
  localparam int unsigned KEY_B_UP   = 2;
  localparam int unsigned KEY_B_DOWN = 3;
  localparam int unsigned KEY_CENTER = 6;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_POS    = 3'd0,
    REG_MAX_POS    = 3'd1,
    REG_CENTER_POS = 3'd2,
    REG_INIT_IVL   = 3'd3,
    REG_FAST_IVL   = 3'd4,
    REG_STEPS      = 3'd5
  } reg_idx_e;

  // reset values
  localparam logic [POS_W-1:0] RST_MIN_POS    = 10'd5;
  localparam logic [POS_W-1:0] RST_MAX_POS    = 10'd1018;
  localparam logic [POS_W-1:0] RST_CENTER_POS = 10'd512;
  localparam logic [IVL_W-1:0] RST_INIT_IVL   = 8'd25;
  localparam logic [IVL_W-1:0] RST_FAST_IVL   = 8'd5;
  localparam logic [IVL_W-1:0] RST_STEPS      = 8'd3;

  // key handling decision shared by all lanes
  typedef struct packed {
    logic take;    // this request ends the loop
    logic act;     // key reading is stable and valid
    logic center;  // center key is down
  } key_ctrl_t;

endpackage

[rtl/core/bdsc_lane.sv]
module bdsc_lane
  import bdsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  key_ctrl_t              ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   up_n_i,
  input  logic                   down_n_i,
  input  logic [POS_W-1:0]       min_pos_i,
  input  logic [POS_W-1:0]       max_pos_i,
  input  logic [POS_W-1:0]       center_pos_i,
  output logic                   drive_o,
  output logic [POS_W-1:0]       position_o
);

  logic [POS_W-1:0] target_q, target_d;
  logic [POS_W-1:0] step_up, step_down, stepped;

  // compare against the target before this request's keys
  assign drive_o = CMP_W'(sample_i) < CMP_W'(target_q);

  always_comb begin
    step_up   = (!up_n_i && target_q < max_pos_i) ? target_q + 1'b1 : target_q;
    step_down = (!down_n_i && step_up > min_pos_i) ? step_up - 1'b1 : step_up;
    stepped   = ctrl_i.center ? center_pos_i : step_down;
    target_d  = ctrl_i.act ? (stepped & POS_MASK) : target_q;
  end

  assign position_o = target_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= RST_CENTER_POS;
    end else if (accept_i) begin
      target_q <= target_d;
    end
  end

endmodule

[rtl/core/bdsc_ctrl.sv]
module bdsc_ctrl
  import bdsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [KEY_W-1:0] keys_i,
  input  logic [IVL_W-1:0] init_ivl_i,
  input  logic [IVL_W-1:0] fast_ivl_i,
  input  logic [IVL_W-1:0] steps_i,
  output key_ctrl_t        ctrl_o
);

  logic [IVL_W-1:0] count_q, count_d;
  logic [IVL_W-1:0] ivl_q, ivl_d;
  logic [IVL_W-1:0] hold_q, hold_d;
  logic [KEY_W-1:0] prev_q, prev_d;
  logic [IVL_W-1:0] count_inc, hold_inc;
  logic             take, act, center;

  always_comb begin
    count_inc = count_q + 1'b1;
    take      = (count_inc >= ivl_q) || (count_inc == '0);
    act       = take && (keys_i == prev_q) && (keys_i < KEY_LIMIT);
    center    = !keys_i[KEY_CENTER];
    hold_inc  = (hold_q < steps_i) ? hold_q + 1'b1 : hold_q;

    count_d = take ? '0 : count_inc;
    prev_d  = take ? keys_i : prev_q;
    ivl_d   = ivl_q;
    hold_d  = hold_q;
    if (act) begin
      if (ivl_q > fast_ivl_i && !center && hold_inc >= steps_i) begin
        ivl_d  = ivl_q - 1'b1;
        hold_d = '0;
      end else begin
        hold_d = hold_inc;
      end
    end else if (take) begin
      ivl_d  = init_ivl_i;
      hold_d = '0;
    end
  end

  assign ctrl_o = '{take: take, act: act, center: center};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ivl_q   <= RST_INIT_IVL;
      hold_q  <= '0;
      prev_q  <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      ivl_q   <= ivl_d;
      hold_q  <= hold_d;
      prev_q  <= prev_d;
    end
  end

endmodule

[rtl/core/button_driven_dual_setpoint_comparator.sv]
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   sample_a_i, sample_b_i, keys_i
// out      output     out_valid_o / out_stall_i drive_a_o, drive_b_o, keys_taken_o,
//                                               position_a_o, position_b_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one request per cycle while in_stall_o is low; its result is registered and shows in the cycle after acceptance
// the loop counter, interval and both targets update in the accept cycle,
// so the next request may follow at once
// reset clears counters and loads the default registers and centered targets
// in_stall_o is high only while a result is held and out_stall_i is high
module button_driven_dual_setpoint_comparator
  import bdsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_a_i,
  input  logic [SAMPLE_BITS-1:0] sample_b_i,
  input  logic [KEY_W-1:0]       keys_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   drive_a_o,
  output logic                   drive_b_o,
  output logic                   keys_taken_o,
  output logic [POS_W-1:0]       position_a_o,
  output logic [POS_W-1:0]       position_b_o
);

  // configuration registers
  logic [POS_W-1:0] min_pos_q, max_pos_q, center_pos_q;
  logic [IVL_W-1:0] init_ivl_q, fast_ivl_q, steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pos_q    <= RST_MIN_POS;
      max_pos_q    <= RST_MAX_POS;
      center_pos_q <= RST_CENTER_POS;
      init_ivl_q   <= RST_INIT_IVL;
      fast_ivl_q   <= RST_FAST_IVL;
      steps_q      <= RST_STEPS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_POS:    min_pos_q    <= cfg_data_i[POS_W-1:0];
        REG_MAX_POS:    max_pos_q    <= cfg_data_i[POS_W-1:0];
        REG_CENTER_POS: center_pos_q <= cfg_data_i[POS_W-1:0];
        REG_INIT_IVL:   init_ivl_q   <= cfg_data_i[IVL_W-1:0];
        REG_FAST_IVL:   fast_ivl_q   <= cfg_data_i[IVL_W-1:0];
        REG_STEPS:      steps_q      <= cfg_data_i[IVL_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // handshake: the output register frees up when its result is taken
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // loop counter and key timing
  key_ctrl_t ctrl;

  bdsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .keys_i     (keys_i),
    .init_ivl_i (init_ivl_q),
    .fast_ivl_i (fast_ivl_q),
    .steps_i    (steps_q),
    .ctrl_o     (ctrl)
  );

  // one lane per channel, both steered by the same key decision
  logic             drive_a, drive_b;
  logic [POS_W-1:0] pos_a, pos_b;

  bdsc_lane u_lane_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .ctrl_i       (ctrl),
    .sample_i     (sample_a_i),
    .up_n_i       (keys_i[KEY_A_UP]),
    .down_n_i     (keys_i[KEY_A_DOWN]),
    .min_pos_i    (min_pos_q),
    .max_pos_i    (max_pos_q),
    .center_pos_i (center_pos_q),
    .drive_o      (drive_a),
    .position_o   (pos_a)
  );

  bdsc_lane u_lane_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .ctrl_i       (ctrl),
    .sample_i     (sample_b_i),
    .up_n_i       (keys_i[KEY_B_UP]),
    .down_n_i     (keys_i[KEY_B_DOWN]),
    .min_pos_i    (min_pos_q),
    .max_pos_i    (max_pos_q),
    .center_pos_i (center_pos_q),
    .drive_o      (drive_b),
    .position_o   (pos_b)
  );

  // merge the lane results into one output register
  logic             drive_a_q, drive_b_q, taken_q;
  logic [POS_W-1:0] pos_a_q, pos_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_a_q <= drive_a;
      drive_b_q <= drive_b;
      taken_q   <= ctrl.take;
      pos_a_q   <= pos_a;
      pos_b_q   <= pos_b;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_a_o    = drive_a_q;
  assign drive_b_o    = drive_b_q;
  assign keys_taken_o = taken_q;
  assign position_a_o = pos_a_q;
  assign position_b_o = pos_b_q;

endmodule
